// ===== hdl/assert_macros.svh =====
// assertion macros for the rtl files that check themselves
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition a in a cycle implies condition b in the same cycle
`define ASSERT_SAME(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("same-cycle check failed");

// condition a in a cycle implies condition b in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("next-cycle check failed");

`endif

// ===== hdl/ipcct_pkg.sv =====
// shared types and constants of the channel token table
// no dependencies
`timescale 1ns / 1ps

package ipcct_pkg;

    localparam int CHANNELS    = 64;
    localparam int CH_BITS     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int INDEX_BITS  = 6;
    localparam int PID_BITS    = 8;
    localparam int LEN_BITS    = 16;
    localparam int HANDLE_BITS = 8;
    localparam int SHM_BITS    = HANDLE_BITS + 1;
    localparam int VALUE_BITS  = LEN_BITS + 1;
    localparam logic [LEN_BITS-1:0] MIN_BUF_RESET = LEN_BITS'(4096);

    typedef enum logic [2:0] {
        OP_OPEN      = 3'd0,
        OP_CLOSE     = 3'd1,
        OP_RING      = 3'd2,
        OP_PEER      = 3'd3,
        OP_WRITE     = 3'd4,
        OP_READ      = 3'd5,
        OP_READY     = 3'd6,
        OP_CLOSE_ALL = 3'd7
    } opcode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_EXEC,
        ST_SCAN_RD,
        ST_SCAN_EV,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic [PID_BITS-1:0]    owner;
        logic [PID_BITS-1:0]    partner;
        logic [PID_BITS-1:0]    holder;
        logic [HANDLE_BITS-1:0] handle;
        logic [LEN_BITS-1:0]    size;
        logic [LEN_BITS-1:0]    cursor;
        logic [LEN_BITS-1:0]    fill;
    } entry_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0]  value;
        logic [1:0]             wake_mask;
        logic [PID_BITS-1:0]    wake_pid_a;
        logic [PID_BITS-1:0]    wake_pid_b;
        logic                   sleep_caller;
        logic [LEN_BITS-1:0]    copy_offset;
        logic [LEN_BITS-1:0]    copy_length;
        logic                   free_valid;
        logic [HANDLE_BITS-1:0] freed_handle;
        logic                   last;
    } result_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic scan_eval;
        logic idx_inc;
        logic flush;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_scan;
        logic stop;
        logic idx_last;
    } ctrl_status_t;

endpackage

// ===== hdl/ipcct_ctrl.sv =====
// sequencer of the channel token table: accepts requests and steps the datapath
// depends on ipcct_pkg
`timescale 1ns / 1ps

module ipcct_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  ipcct_pkg::ctrl_status_t status,
    output ipcct_pkg::ctrl_cmd_t    cmd,
    output logic                  busy
);
    import ipcct_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_FETCH;
                end
            end
            // entry read is in flight during this cycle
            ST_FETCH:
            begin
                state_next = status.is_scan ? ST_SCAN_EV : ST_EXEC;
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = ST_IDLE;
            end
            ST_SCAN_RD:
            begin
                state_next = ST_SCAN_EV;
            end
            ST_SCAN_EV:
            begin
                cmd.scan_eval = 1'b1;
                if (status.stop)
                begin
                    state_next = ST_IDLE;
                end
                else if (status.idx_last)
                begin
                    state_next = ST_FLUSH;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ST_SCAN_RD;
                end
            end
            ST_FLUSH:
            begin
                cmd.flush  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/ipcct_dpath.sv =====
// datapath of the channel token table: request latch, entry memory, open bits,
// scan index, config register and result register; depends on ipcct_pkg
`timescale 1ns / 1ps

module ipcct_dpath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ipcct_pkg::ctrl_cmd_t                cmd,
    output ipcct_pkg::ctrl_status_t             status,
    input  logic                                cfg_we,
    input  logic [ipcct_pkg::LEN_BITS-1:0]      cfg_data,
    input  logic [2:0]                          opcode,
    input  logic [ipcct_pkg::PID_BITS-1:0]      caller_pid,
    input  logic [ipcct_pkg::INDEX_BITS-1:0]    channel_index,
    input  logic [ipcct_pkg::PID_BITS-1:0]      other_pid,
    input  logic [ipcct_pkg::LEN_BITS-1:0]      length,
    input  logic [ipcct_pkg::SHM_BITS-1:0]      shm_handle,
    input  logic                                map_ok,
    output ipcct_pkg::result_t                  res,
    output logic                                res_valid
);
    import ipcct_pkg::*;

    localparam logic [VALUE_BITS-1:0] VALUE_FAIL = '1;

    entry_t mem [CHANNELS];
    entry_t rd_reg;

    opcode_t                op_reg;
    logic [PID_BITS-1:0]    caller_reg;
    logic [INDEX_BITS-1:0]  chan_reg;
    logic [PID_BITS-1:0]    other_reg;
    logic [LEN_BITS-1:0]    len_reg;
    logic [SHM_BITS-1:0]    shm_reg;
    logic                   map_reg;
    logic [LEN_BITS-1:0]    min_buf_reg;
    logic [CH_BITS-1:0]     idx_reg;
    logic [CHANNELS-1:0]    open_reg;
    result_t                res_reg;
    result_t                res_next;
    logic                   res_valid_reg;
    logic                   res_valid_next;
    result_t                pend_reg;
    result_t                pend_next;
    logic                   pend_valid_reg;
    logic                   pend_valid_next;

    logic                   is_scan;
    logic [CH_BITS-1:0]     ch_addr;
    logic                   chan_ok;
    logic                   chan_open;
    logic [CH_BITS-1:0]     rd_addr;
    logic                   mem_we;
    logic [CH_BITS-1:0]     mem_addr;
    entry_t                 mem_wd;
    logic                   open_we;
    logic [CH_BITS-1:0]     open_addr;
    logic                   open_val;
    logic                   is_owner;
    logic                   is_partner;
    logic                   holds;
    logic [PID_BITS-1:0]    other_party;
    logic [LEN_BITS:0]      sum;
    logic [LEN_BITS-1:0]    wsize;
    logic [LEN_BITS-1:0]    rsize;
    logic                   rend;
    logic [LEN_BITS-1:0]    want;
    logic                   idx_open;
    logic                   scan_hit;
    result_t                close_res;

    assign is_scan = (op_reg == OP_OPEN) || (op_reg == OP_READY) || (op_reg == OP_CLOSE_ALL);
    assign ch_addr = chan_reg[CH_BITS-1:0];
    assign chan_ok = {1'b0, chan_reg} < (INDEX_BITS + 1)'(CHANNELS);
    assign chan_open = chan_ok && open_reg[ch_addr];
    assign rd_addr = is_scan ? idx_reg : ch_addr;
    assign idx_open = open_reg[idx_reg];

    assign is_owner    = rd_reg.owner == caller_reg;
    assign is_partner  = rd_reg.partner == caller_reg;
    assign holds       = rd_reg.holder == caller_reg;
    assign other_party = is_owner ? rd_reg.partner : rd_reg.owner;
    assign sum         = {1'b0, len_reg} + {1'b0, rd_reg.cursor};
    assign want        = (len_reg < min_buf_reg) ? min_buf_reg : len_reg;

    // write clamp against the buffer size
    always_comb
    begin
        wsize = len_reg;
        if (sum > {1'b0, rd_reg.size})
        begin
            wsize = (rd_reg.cursor < rd_reg.size) ? rd_reg.size - rd_reg.cursor : '0;
        end
    end

    // read clamp against the fill mark
    always_comb
    begin
        rsize = len_reg;
        rend  = 1'b0;
        if (sum >= {1'b0, rd_reg.fill})
        begin
            rsize = (rd_reg.cursor < rd_reg.fill) ? rd_reg.fill - rd_reg.cursor : '0;
            rend  = 1'b1;
        end
    end

    always_comb
    begin
        scan_hit = 1'b0;
        case (op_reg)
            OP_OPEN:      scan_hit = !idx_open;
            OP_READY:     scan_hit = idx_open && holds;
            default:      scan_hit = 1'b0;
        endcase
    end

    always_comb
    begin
        close_res              = '0;
        close_res.free_valid   = 1'b1;
        close_res.freed_handle = rd_reg.handle;
        close_res.wake_mask    = 2'b11;
        close_res.wake_pid_a   = rd_reg.owner;
        close_res.wake_pid_b   = rd_reg.partner;
    end

    assign status.is_scan  = is_scan;
    assign status.stop     = scan_hit;
    assign status.idx_last = idx_reg == CH_BITS'(CHANNELS - 1);

    always_comb
    begin
        res_next        = '0;
        res_next.last   = 1'b1;
        res_valid_next  = 1'b0;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        mem_we          = 1'b0;
        mem_addr        = ch_addr;
        mem_wd          = rd_reg;
        open_we         = 1'b0;
        open_addr       = ch_addr;
        open_val        = 1'b0;

        if (cmd.load)
        begin
            pend_valid_next = 1'b0;
        end

        if (cmd.exec)
        begin
            res_valid_next = 1'b1;
            case (op_reg)
                OP_CLOSE:
                begin
                    if (chan_open && (is_owner || is_partner))
                    begin
                        res_next      = close_res;
                        res_next.last = 1'b1;
                        open_we       = 1'b1;
                    end
                end
                OP_RING:
                begin
                    if (!chan_open)
                    begin
                        res_next.value = VALUE_FAIL;
                    end
                    else if (holds)
                    begin
                        res_next.wake_mask  = 2'b01;
                        res_next.wake_pid_a = other_party;
                        mem_we              = 1'b1;
                        mem_wd.holder       = other_party;
                        mem_wd.cursor       = '0;
                    end
                end
                OP_PEER:
                begin
                    res_next.value = chan_open ? VALUE_BITS'(other_party) : VALUE_FAIL;
                end
                OP_WRITE:
                begin
                    if (chan_open && (len_reg != '0))
                    begin
                        if (!holds)
                        begin
                            res_next.sleep_caller = 1'b1;
                            res_next.value        = VALUE_FAIL;
                        end
                        else if (map_reg && (wsize != '0))
                        begin
                            res_next.copy_offset = rd_reg.cursor;
                            res_next.copy_length = wsize;
                            res_next.value       = {1'b0, wsize};
                            mem_we               = 1'b1;
                            mem_wd.cursor        = rd_reg.cursor + wsize;
                            mem_wd.fill          = rd_reg.cursor + wsize;
                        end
                    end
                end
                OP_READ:
                begin
                    if (chan_open && (len_reg != '0))
                    begin
                        if (!holds)
                        begin
                            res_next.sleep_caller = 1'b1;
                            res_next.value        = VALUE_FAIL;
                        end
                        else if (map_reg)
                        begin
                            res_next.copy_offset = rd_reg.cursor;
                            res_next.copy_length = rsize;
                            res_next.value       = {1'b0, rsize};
                            mem_we               = 1'b1;
                            if (rend)
                            begin
                                mem_wd.cursor = '0;
                                mem_wd.fill   = '0;
                            end
                            else
                            begin
                                mem_wd.cursor = rd_reg.cursor + rsize;
                            end
                        end
                    end
                end
                default:
                begin
                    res_next.value = '0;
                end
            endcase
        end

        if (cmd.scan_eval)
        begin
            mem_addr  = idx_reg;
            open_addr = idx_reg;
            case (op_reg)
                OP_OPEN:
                begin
                    if (!idx_open)
                    begin
                        res_valid_next = 1'b1;
                        if (shm_reg[SHM_BITS-1])
                        begin
                            res_next.value = VALUE_FAIL;
                        end
                        else
                        begin
                            mem_we              = 1'b1;
                            mem_wd.owner        = caller_reg;
                            mem_wd.holder       = caller_reg;
                            mem_wd.partner      = other_reg;
                            mem_wd.handle       = shm_reg[HANDLE_BITS-1:0];
                            mem_wd.size         = want;
                            mem_wd.cursor       = '0;
                            mem_wd.fill         = '0;
                            open_we             = 1'b1;
                            open_val            = 1'b1;
                            res_next.value      = VALUE_BITS'(idx_reg);
                            res_next.wake_mask  = 2'b11;
                            res_next.wake_pid_a = caller_reg;
                            res_next.wake_pid_b = other_reg;
                        end
                    end
                end
                OP_READY:
                begin
                    if (scan_hit)
                    begin
                        res_valid_next = 1'b1;
                        res_next.value = VALUE_BITS'(idx_reg);
                    end
                end
                OP_CLOSE_ALL:
                begin
                    if (idx_open
                        && ((rd_reg.owner == other_reg) || (rd_reg.partner == other_reg))
                        && (is_owner || is_partner))
                    begin
                        open_we = 1'b1;
                        // previous close goes out now, it is not the final one
                        if (pend_valid_reg)
                        begin
                            res_next       = pend_reg;
                            res_next.last  = 1'b0;
                            res_valid_next = 1'b1;
                        end
                        pend_next       = close_res;
                        pend_valid_next = 1'b1;
                    end
                end
                default:
                begin
                    res_valid_next = 1'b0;
                end
            endcase
        end

        if (cmd.flush)
        begin
            res_valid_next = 1'b1;
            case (op_reg)
                OP_OPEN:
                begin
                    res_next.value = VALUE_FAIL;
                end
                OP_READY:
                begin
                    res_next.value        = VALUE_FAIL;
                    res_next.sleep_caller = 1'b1;
                end
                default:
                begin
                    if (pend_valid_reg)
                    begin
                        res_next = pend_reg;
                    end
                    res_next.last = 1'b1;
                end
            endcase
        end
    end

    // entry memory, read data registered
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wd;
        end
        rd_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= opcode_t'(opcode);
            caller_reg <= caller_pid;
            chan_reg   <= channel_index;
            other_reg  <= other_pid;
            len_reg    <= length;
            shm_reg    <= shm_handle;
            map_reg    <= map_ok;
        end
        res_reg  <= res_next;
        pend_reg <= pend_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_buf_reg    <= MIN_BUF_RESET;
            idx_reg        <= '0;
            open_reg       <= '0;
            res_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                min_buf_reg <= cfg_data;
            end
            if (cmd.load)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (open_we)
            begin
                open_reg[open_addr] <= open_val;
            end
            res_valid_reg  <= res_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    assign res       = res_reg;
    assign res_valid = res_valid_reg;

endmodule

// ===== hdl/ipc_channel_token_table.sv =====
// top level of the channel token table: sequencer plus datapath, port checks
// depends on ipcct_pkg, ipcct_ctrl, ipcct_dpath and assert_macros.svh
`timescale 1ns / 1ps

// A request is taken when start is high and busy is low; busy then stays high
// until its last result is shown. Results appear one per cycle with
// result_valid and cannot be held off; last marks the final one. close, ring,
// peer, write and read pass through the fetch and execute states before their
// result. open, ready and close_all walk the channel entries in index order,
// with a fetch or read state and an evaluate state per entry through the entry
// memory with its registered read; open and ready stop at the first hit. The
// min_buffer_size register is written through cfg_valid / cfg_ready, which is
// ready whenever the block is not busy.

`include "assert_macros.svh"

module ipc_channel_token_table (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [2:0]                          opcode,
    input  logic [ipcct_pkg::PID_BITS-1:0]      caller_pid,
    input  logic [ipcct_pkg::INDEX_BITS-1:0]    channel_index,
    input  logic [ipcct_pkg::PID_BITS-1:0]      other_pid,
    input  logic [ipcct_pkg::LEN_BITS-1:0]      length,
    input  logic signed [ipcct_pkg::SHM_BITS-1:0] shm_handle,
    input  logic                                map_ok,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ipcct_pkg::LEN_BITS-1:0]      cfg_data,
    output logic                                result_valid,
    output logic signed [ipcct_pkg::VALUE_BITS-1:0] result_value,
    output logic [1:0]                          wake_mask,
    output logic [ipcct_pkg::PID_BITS-1:0]      wake_pid_a,
    output logic [ipcct_pkg::PID_BITS-1:0]      wake_pid_b,
    output logic                                sleep_caller,
    output logic [ipcct_pkg::LEN_BITS-1:0]      copy_offset,
    output logic [ipcct_pkg::LEN_BITS-1:0]      copy_length,
    output logic                                free_valid,
    output logic [ipcct_pkg::HANDLE_BITS-1:0]   freed_handle,
    output logic                                last
);
    import ipcct_pkg::*;

    ctrl_cmd_t    cmd;
    ctrl_status_t status;
    result_t      res;

    ipcct_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    assign cfg_ready = !busy;

    ipcct_dpath u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_data      (cfg_data),
        .opcode        (opcode),
        .caller_pid    (caller_pid),
        .channel_index (channel_index),
        .other_pid     (other_pid),
        .length        (length),
        .shm_handle    (shm_handle),
        .map_ok        (map_ok),
        .res           (res),
        .res_valid     (result_valid)
    );

    assign result_value = res.value;
    assign wake_mask    = res.wake_mask;
    assign wake_pid_a   = res.wake_pid_a;
    assign wake_pid_b   = res.wake_pid_b;
    assign sleep_caller = res.sleep_caller;
    assign copy_offset  = res.copy_offset;
    assign copy_length  = res.copy_length;
    assign free_valid   = res.free_valid;
    assign freed_handle = res.freed_handle;
    assign last         = res.last;

    // the final transfer of a request releases the block in the same cycle
    `ASSERT_SAME(a_last_frees, clk, rst_n, result_valid && last, !busy)
    // more results still to come keep the block busy
    `ASSERT_SAME(a_more_busy, clk, rst_n, result_valid && !last, busy)
    // a fresh request never shows a result in the cycle after it is taken
    `ASSERT_NEXT(a_no_early, clk, rst_n, start && !busy, !result_valid && busy)

endmodule

// ===== tb/sv/tb_ipc_channel_token_table.sv =====
// self-checking bench for the channel token table: random and directed requests
// with a behavioral predictor and an in-order result check; depends on ipcct_pkg
`timescale 1ns / 1ps

module tb_ipc_channel_token_table;
    import ipcct_pkg::*;

    typedef struct {
        opcode_t          op;
        logic [7:0]       caller;
        logic [5:0]       chan;
        logic [7:0]       other;
        logic [15:0]      len;
        logic signed [8:0] shm;
        logic             map;
        bit               is_cfg;
        logic [15:0]      cfg_val;
        bit               drain;
    } request_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic [2:0] opcode;
    logic [7:0] caller_pid;
    logic [5:0] channel_index;
    logic [7:0] other_pid;
    logic [15:0] length;
    logic signed [8:0] shm_handle;
    logic map_ok;
    logic cfg_valid;
    logic cfg_ready;
    logic [15:0] cfg_data;
    logic result_valid;
    logic signed [16:0] result_value;
    logic [1:0] wake_mask;
    logic [7:0] wake_pid_a;
    logic [7:0] wake_pid_b;
    logic sleep_caller;
    logic [15:0] copy_offset;
    logic [15:0] copy_length;
    logic free_valid;
    logic [7:0] freed_handle;
    logic last;

    ipc_channel_token_table dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .opcode(opcode), .caller_pid(caller_pid), .channel_index(channel_index),
        .other_pid(other_pid), .length(length), .shm_handle(shm_handle),
        .map_ok(map_ok), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_data(cfg_data), .result_valid(result_valid),
        .result_value(result_value), .wake_mask(wake_mask),
        .wake_pid_a(wake_pid_a), .wake_pid_b(wake_pid_b),
        .sleep_caller(sleep_caller), .copy_offset(copy_offset),
        .copy_length(copy_length), .free_valid(free_valid),
        .freed_handle(freed_handle), .last(last)
    );

    // table shadow
    logic [15:0] min_size;
    bit          t_open [64];
    logic [7:0]  t_holder [64];
    logic [7:0]  t_owner [64];
    logic [7:0]  t_partner [64];
    logic [7:0]  t_handle [64];
    logic [15:0] t_size [64];
    logic [15:0] t_cursor [64];
    logic [15:0] t_fill [64];

    request_t pending_requests[$];
    result_t  expected_results[$];
    int       mismatches = 0;

    task automatic report(input string what);
        $display("mismatch %0t: %s", $time, what);
        mismatches++;
    endtask

    function automatic void clear_slot(input int i);
        t_open[i] = 0; t_holder[i] = 0; t_owner[i] = 0; t_partner[i] = 0;
        t_handle[i] = 0; t_size[i] = 0; t_cursor[i] = 0; t_fill[i] = 0;
    endfunction

    function automatic result_t blank_result();
        result_t r;
        r = '0;
        return r;
    endfunction

    // closes slot i into r when the caller is a party
    function automatic bit close_slot(input int i, input logic [7:0] caller,
                                      inout result_t r);
        if (!t_open[i]) return 0;
        if (t_owner[i] != caller && t_partner[i] != caller) return 0;
        r.free_valid = 1; r.freed_handle = t_handle[i];
        r.wake_mask = 2'b11; r.wake_pid_a = t_owner[i]; r.wake_pid_b = t_partner[i];
        clear_slot(i);
        return 1;
    endfunction

    task automatic predict_channel_request(input request_t q);
        result_t r;
        logic [15:0] want;
        logic [16:0] sum;
        logic [15:0] sz;
        bit hit;
        bit at_end;
        int c;
        r = blank_result();
        c = q.chan;
        case (q.op)
            OP_OPEN: begin
                want = (q.len < min_size) ? min_size : q.len;
                r.value = '1;
                for (int i = 0; i < 64; i++)
                    if (!t_open[i]) begin
                        if (q.shm >= 0) begin
                            clear_slot(i);
                            t_open[i] = 1; t_handle[i] = q.shm[7:0]; t_size[i] = want;
                            t_holder[i] = q.caller; t_owner[i] = q.caller;
                            t_partner[i] = q.other;
                            r.wake_mask = 2'b11; r.wake_pid_a = q.caller;
                            r.wake_pid_b = q.other; r.value = 17'(i);
                        end
                        break;
                    end
            end
            OP_CLOSE: begin
                hit = close_slot(c, q.caller, r);
                r.value = 0;
            end
            OP_RING: begin
                if (!t_open[c]) r.value = '1;
                else begin
                    r.value = 0;
                    if (t_holder[c] == q.caller) begin
                        t_holder[c] = (t_owner[c] == q.caller) ? t_partner[c] : t_owner[c];
                        r.wake_mask = 2'b01; r.wake_pid_a = t_holder[c];
                        t_cursor[c] = 0;
                    end
                end
            end
            OP_PEER: begin
                if (!t_open[c]) r.value = '1;
                else r.value = 17'((t_owner[c] == q.caller) ? t_partner[c] : t_owner[c]);
            end
            OP_WRITE: begin
                r.value = 0;
                if (t_open[c] && q.len != 0) begin
                    if (t_holder[c] != q.caller) begin
                        r.sleep_caller = 1; r.value = '1;
                    end else begin
                        sz = q.len;
                        sum = {1'b0, q.len} + {1'b0, t_cursor[c]};
                        if (sum > {1'b0, t_size[c]})
                            sz = (t_cursor[c] < t_size[c]) ? t_size[c] - t_cursor[c] : 16'd0;
                        if (q.map && sz != 0) begin
                            r.copy_offset = t_cursor[c]; r.copy_length = sz;
                            t_cursor[c] = t_cursor[c] + sz;
                            t_fill[c] = t_cursor[c];
                            r.value = {1'b0, sz};
                        end
                    end
                end
            end
            OP_READ: begin
                r.value = 0;
                if (t_open[c] && q.len != 0) begin
                    if (t_holder[c] != q.caller) begin
                        r.sleep_caller = 1; r.value = '1;
                    end else begin
                        sz = q.len;
                        at_end = 0;
                        sum = {1'b0, q.len} + {1'b0, t_cursor[c]};
                        if (sum >= {1'b0, t_fill[c]}) begin
                            sz = (t_cursor[c] < t_fill[c]) ? t_fill[c] - t_cursor[c] : 16'd0;
                            at_end = 1;
                        end
                        if (q.map) begin
                            r.copy_offset = t_cursor[c]; r.copy_length = sz;
                            if (at_end) begin
                                t_cursor[c] = 0; t_fill[c] = 0;
                            end else t_cursor[c] = t_cursor[c] + sz;
                            r.value = {1'b0, sz};
                        end
                    end
                end
            end
            OP_READY: begin
                r.value = '1;
                hit = 0;
                for (int i = 0; i < 64; i++)
                    if (t_open[i] && t_holder[i] == q.caller) begin
                        r.value = 17'(i);
                        hit = 1;
                        break;
                    end
                if (!hit) r.sleep_caller = 1;
            end
            default: begin
                hit = 0;
                for (int i = 0; i < 64; i++) begin
                    result_t one;
                    one = blank_result();
                    if (t_open[i] && (t_owner[i] == q.other || t_partner[i] == q.other))
                        if (close_slot(i, q.caller, one)) begin
                            expected_results.push_back(one);
                            hit = 1;
                        end
                end
                if (hit) begin
                    expected_results[$].last = 1;
                    return;
                end
            end
        endcase
        r.last = 1;
        expected_results.push_back(r);
    endtask

    initial begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    initial begin
        #5000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // driver
    request_t cur;
    int gap = 0;
    bit have_cur = 0;
    int drain_wait = 0;
    logic busy_q, cfg_ready_q;

    always @(negedge clk) begin
        if (!rst_n) begin
            start <= 0; cfg_valid <= 0;
        end else begin
            // retire what was taken at the last rising edge
            if (have_cur && ((start && !busy_q) || (cfg_valid && cfg_ready_q))) begin
                have_cur = 0;
                gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                  : $urandom_range(0, 2);
                if ($urandom_range(0, 3) == 0) gap = 0;
            end
            if (!have_cur && gap > 0) gap--;
            else if (!have_cur && pending_requests.size() > 0) begin
                cur = pending_requests.pop_front();
                have_cur = 1;
                drain_wait = 0;
            end
            if (have_cur && (cur.is_cfg || cur.drain)) begin
                // idle: no result outstanding, then settle past the longest scan
                if (expected_results.size() != 0 || busy_q) drain_wait = 0;
                else drain_wait++;
            end
            if (have_cur && cur.drain && drain_wait > 140) begin
                have_cur = 0;
                start <= 0; cfg_valid <= 0;
            end else if (have_cur && cur.is_cfg) begin
                start <= 0;
                cfg_valid <= (drain_wait > 140);
                cfg_data <= cur.cfg_val;
            end else if (have_cur && !cur.drain) begin
                cfg_valid <= 0;
                start <= 1;
                opcode <= cur.op; caller_pid <= cur.caller; channel_index <= cur.chan;
                other_pid <= cur.other; length <= cur.len; shm_handle <= cur.shm;
                map_ok <= cur.map;
            end else begin
                start <= 0; cfg_valid <= 0;
            end
        end
    end

    // sampled handshake state at the rising edge
    always @(posedge clk) begin
        busy_q <= busy;
        cfg_ready_q <= cfg_ready;
        if (rst_n && start && !busy && have_cur && !cur.is_cfg) predict_channel_request(cur);
        if (rst_n && cfg_valid && cfg_ready) min_size <= cfg_data;
    end

    // monitor
    always @(posedge clk) begin
        if (rst_n && result_valid) begin
            result_t exp_r;
            if (expected_results.size() == 0) report("result with nothing expected");
            else begin
                exp_r = expected_results.pop_front();
                if (result_value !== exp_r.value)
                    report($sformatf("value %0d exp %0d", result_value, $signed(exp_r.value)));
                if (wake_mask !== exp_r.wake_mask) report("wake_mask");
                if (wake_pid_a !== exp_r.wake_pid_a) report("wake_pid_a");
                if (wake_pid_b !== exp_r.wake_pid_b) report("wake_pid_b");
                if (sleep_caller !== exp_r.sleep_caller) report("sleep_caller");
                if (copy_offset !== exp_r.copy_offset) report("copy_offset");
                if (copy_length !== exp_r.copy_length) report("copy_length");
                if (free_valid !== exp_r.free_valid) report("free_valid");
                if (freed_handle !== exp_r.freed_handle) report("freed_handle");
                if (last !== exp_r.last) report("last");
            end
        end
    end

    function automatic request_t mk(input opcode_t op, input logic [7:0] caller,
                                    input logic [5:0] chan, input logic [7:0] other,
                                    input logic [15:0] len, input int shm, input bit map);
        request_t q;
        q.op = op; q.caller = caller; q.chan = chan; q.other = other; q.len = len;
        q.shm = 9'(shm); q.map = map; q.is_cfg = 0; q.cfg_val = 0; q.drain = 0;
        return q;
    endfunction

    function automatic request_t mk_cfg(input logic [15:0] v);
        request_t q;
        q = mk(OP_PEER, 0, 0, 0, 0, 0, 0);
        q.is_cfg = 1; q.cfg_val = v;
        return q;
    endfunction

    function automatic request_t mk_drain();
        request_t q;
        q = mk(OP_PEER, 0, 0, 0, 0, 0, 0);
        q.drain = 1;
        return q;
    endfunction

    // random request drawn from a small pid pool so that channels get exercised
    function automatic request_t rand_request();
        logic [7:0] pids[4];
        request_t q;
        int k;
        pids = '{8'd1, 8'd2, 8'd3, 8'd255};
        k = $urandom_range(0, 99);
        q = mk(opcode_t'($urandom_range(0, 7)), pids[$urandom_range(0, 3)],
               $urandom_range(0, 7), pids[$urandom_range(0, 3)],
               $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535)
                                         : $urandom_range(0, 300),
               $urandom_range(0, 9) == 0 ? -1 : $urandom_range(0, 255),
               $urandom_range(0, 7) != 0);
        if (k < 5) q.caller = $urandom_range(0, 255);
        if (k < 3) q.chan = $urandom_range(0, 63);
        if (k >= 95) q.other = $urandom_range(0, 255);
        if (q.op == OP_OPEN && $urandom_range(0, 1)) q.len = $urandom_range(0, 65535);
        return q;
    endfunction

    initial begin
        logic [15:0] cfgs[4];
        rst_n = 0; start = 0; cfg_valid = 0; cfg_data = 0;
        opcode = 0; caller_pid = 0; channel_index = 0; other_pid = 0;
        length = 0; shm_handle = 0; map_ok = 0;
        min_size = MIN_BUF_RESET;
        for (int i = 0; i < 64; i++) clear_slot(i);
        repeat (10) @(posedge clk);
        @(negedge clk) rst_n = 1;

        // directed: lifecycle, clamps, strangers, no-token cases
        pending_requests.push_back(mk(OP_READY, 5, 0, 0, 0, 0, 1));
        pending_requests.push_back(mk(OP_PEER, 5, 63, 0, 0, 0, 1));
        pending_requests.push_back(mk(OP_OPEN, 5, 0, 9, 0, 255, 1));
        pending_requests.push_back(mk(OP_OPEN, 0, 0, 255, 16'hFFFF, 0, 1));
        pending_requests.push_back(mk(OP_OPEN, 5, 0, 9, 10, -1, 1));
        pending_requests.push_back(mk(OP_WRITE, 5, 0, 0, 16'hFFFF, 0, 1));
        pending_requests.push_back(mk(OP_WRITE, 5, 0, 0, 5, 0, 1));
        pending_requests.push_back(mk(OP_WRITE, 9, 0, 0, 5, 0, 1));
        pending_requests.push_back(mk(OP_RING, 9, 0, 0, 0, 0, 1));
        pending_requests.push_back(mk(OP_RING, 5, 0, 0, 0, 0, 1));
        pending_requests.push_back(mk(OP_WRITE, 9, 0, 0, 100, 0, 0));
        pending_requests.push_back(mk(OP_WRITE, 9, 0, 0, 0, 0, 1));
        pending_requests.push_back(mk(OP_WRITE, 9, 0, 0, 100, 0, 1));
        pending_requests.push_back(mk(OP_READ, 9, 0, 0, 40, 0, 1));
        pending_requests.push_back(mk(OP_READ, 9, 0, 0, 40, 0, 0));
        pending_requests.push_back(mk(OP_READ, 9, 0, 0, 16'hFFFF, 0, 1));
        pending_requests.push_back(mk(OP_READY, 9, 0, 0, 0, 0, 1));
        pending_requests.push_back(mk(OP_PEER, 9, 0, 0, 0, 0, 1));
        pending_requests.push_back(mk(OP_CLOSE, 77, 0, 0, 0, 0, 1));
        pending_requests.push_back(mk(OP_CLOSE_ALL, 77, 0, 9, 0, 0, 1));
        pending_requests.push_back(mk(OP_CLOSE_ALL, 9, 0, 9, 0, 0, 1));
        pending_requests.push_back(mk(OP_CLOSE, 0, 1, 0, 0, 0, 1));
        pending_requests.push_back(mk(OP_CLOSE, 0, 1, 0, 0, 0, 1));
        pending_requests.push_back(mk_drain());

        // fill every slot, then overflow
        for (int i = 0; i < 65; i++)
            pending_requests.push_back(mk(OP_OPEN, 1, 0, 2, 1, i & 255, 1));
        pending_requests.push_back(mk(OP_READY, 2, 0, 0, 0, 0, 1));
        pending_requests.push_back(mk(OP_CLOSE_ALL, 2, 0, 1, 0, 0, 1));

        cfgs = '{16'd1, 16'hFFFF, 16'd64, 16'd4096};
        for (int ph = 0; ph < 4; ph++) begin
            pending_requests.push_back(mk_cfg(cfgs[ph]));
            for (int n = 0; n < 85; n++) pending_requests.push_back(rand_request());
            pending_requests.push_back(mk(OP_CLOSE_ALL, 1, 0, 2, 0, 0, 1));
        end
        while (pending_requests.size() != 0) @(posedge clk);
        while (have_cur) @(posedge clk);
        while (expected_results.size() != 0) @(posedge clk);
        repeat (150) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
